// ----- src/cpfs_pkg.sv -----
package cpfs_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int FLIGHT_SLOTS_DEF = 8;
    localparam int KEY_BITS_DEF     = 16;
    localparam int REASON_BITS_DEF  = 16;
    localparam int BAND_BITS        = 3;
    localparam int ORDER_BITS       = 32;
    localparam int LIMIT_BITS       = 4;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 4'd4;

    localparam logic CMD_ENQUEUE  = 1'b0;
    localparam logic CMD_COMPLETE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_PICK,
        ST_OUT
    } t_state;

endpackage

// ----- src/coalescing_priority_fetch_scheduler_top.sv -----
// Coalescing priority fetch scheduler.
// Input stream (s_axis): tdata carries job_key, job_reason, job_priority,
// tuser carries command (0 enqueue, 1 complete). Output stream (m_axis):
// one result transaction per input transaction, tdata carries dispatch
// key, reason, priority, enqueue_dropped and queued_count, tuser carries
// dispatch_valid. i_cfg_we/i_cfg_wdata write max_in_flight; write it only
// while no transaction is being worked.
// Each item makes two passes over the queue memory, one entry a cycle:
// a key match pass, an apply step that writes the merged or appended
// entry, a selection pass and an output step that records the dispatch.
// A new item is accepted only in the idle state, after the result of the
// last one has been loaded into the output register.
// Reset clears all used bits and the order counter and sets max_in_flight
// to 4; memory contents need no clearing since the used bits gate reads.
// When the receiver stalls the result is held in the output register; the
// next item may be taken and worked, but it waits in the output step until
// the held result is taken, and no further item is accepted meanwhile.
module coalescing_priority_fetch_scheduler_top
    import cpfs_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int FLIGHT_SLOTS = FLIGHT_SLOTS_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int REASON_BITS  = REASON_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [LIMIT_BITS-1:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // job_key, job_reason, job_priority, zero fill
    input  logic [((KEY_BITS+REASON_BITS+BAND_BITS+7)/8)*8-1:0] s_axis_tdata,
    // command
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // dispatch_key, dispatch_reason, dispatch_priority, enqueue_dropped,
    // queued_count, zero fill
    output logic [((KEY_BITS+REASON_BITS+BAND_BITS+1+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0]
                        m_axis_tdata,
    // dispatch_valid
    output logic        m_axis_tuser
);

    localparam int QA = $clog2(QUEUE_DEPTH);
    localparam int FA = (FLIGHT_SLOTS > 1) ? $clog2(FLIGHT_SLOTS) : 1;
    localparam int CB = $clog2(QUEUE_DEPTH + 1);
    localparam int FC = $clog2(FLIGHT_SLOTS + 1);
    localparam int EW = KEY_BITS + REASON_BITS + BAND_BITS + ORDER_BITS;
    localparam int OW = ((KEY_BITS+REASON_BITS+BAND_BITS+1+CB+7)/8)*8;

    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [REASON_BITS-1:0] reason;
        logic [BAND_BITS-1:0]   band;
        logic [ORDER_BITS-1:0]  order;
    } t_entry;

    t_state r_state, n_state;

    // configuration and control registers
    logic [LIMIT_BITS-1:0]  r_limit;
    logic [ORDER_BITS-1:0]  r_counter;
    logic [QUEUE_DEPTH-1:0] r_qused;
    logic [CB-1:0]          r_qcount;
    // flight slots are few and all searched at once
    logic [FLIGHT_SLOTS-1:0] r_fused, r_rused;
    logic [KEY_BITS-1:0]     r_fkey  [FLIGHT_SLOTS];
    logic [REASON_BITS-1:0]  r_freason [FLIGHT_SLOTS];
    logic [REASON_BITS-1:0]  r_rreason [FLIGHT_SLOTS];
    logic [BAND_BITS-1:0]    r_rband [FLIGHT_SLOTS];

    // captured input
    logic                   r_cmd;
    logic [KEY_BITS-1:0]    r_key;
    logic [REASON_BITS-1:0] r_reason;
    logic [BAND_BITS-1:0]   r_band;

    // scan bookkeeping
    logic [QA:0]            r_idx;      // address issued
    logic                   r_rdv;      // read data valid
    logic [QA-1:0]          r_rdaddr;
    logic                   r_hit;
    logic [QA-1:0]          r_hit_idx;
    t_entry                 r_hit_ent;
    logic                   r_best_v;
    logic [QA-1:0]          r_best_idx;
    t_entry                 r_best_ent;
    logic                   r_dropped;

    // outputs
    logic                   r_ovalid;
    logic                   r_dv;
    logic [KEY_BITS-1:0]    r_okey;
    logic [REASON_BITS-1:0] r_oreason;
    logic [BAND_BITS-1:0]   r_oband;
    logic                   r_odrop;
    logic [CB-1:0]          r_ocount;

    // memory port
    logic          w_we;
    logic [QA-1:0] w_waddr, w_raddr;
    t_entry        w_wdata, w_rdata;

    cpfs_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_dv;
    assign m_axis_tdata  = OW'({r_ocount, r_odrop, r_oband, r_oreason, r_okey});

    // flight slot match for the captured key
    logic          w_fhit;
    logic [FA-1:0] w_fidx;
    always_comb begin
        w_fhit = 1'b0;
        w_fidx = '0;
        for (int i = 0; i < FLIGHT_SLOTS; i++) begin
            if (!w_fhit && r_fused[i] && r_fkey[i] == r_key) begin
                w_fhit = 1'b1;
                w_fidx = FA'(i);
            end
        end
    end

    // is the scanned entry's key in flight
    logic w_rd_inflight;
    always_comb begin
        w_rd_inflight = 1'b0;
        for (int i = 0; i < FLIGHT_SLOTS; i++) begin
            if (r_fused[i] && r_fkey[i] == w_rdata.key) begin
                w_rd_inflight = 1'b1;
            end
        end
    end

    // first free flight slot and busy count
    logic          w_ffree;
    logic [FA-1:0] w_ffidx;
    logic [FC-1:0] w_busy;
    always_comb begin
        w_ffree = 1'b0;
        w_ffidx = '0;
        w_busy  = '0;
        for (int i = 0; i < FLIGHT_SLOTS; i++) begin
            if (r_fused[i]) begin
                w_busy = w_busy + FC'(1);
            end else if (!w_ffree) begin
                w_ffree = 1'b1;
                w_ffidx = FA'(i);
            end
        end
    end

    // first free queue entry
    logic          w_qfree;
    logic [QA-1:0] w_qfidx;
    always_comb begin
        w_qfree = 1'b0;
        w_qfidx = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (!w_qfree && !r_qused[i]) begin
                w_qfree = 1'b1;
                w_qfidx = QA'(i);
            end
        end
    end

    // limit above the slot count acts as the slot count
    logic [FC-1:0] w_limit;
    assign w_limit = (int'(r_limit) > FLIGHT_SLOTS) ? FC'(FLIGHT_SLOTS) : FC'(r_limit);

    logic w_scan_done;
    assign w_scan_done = r_rdv && (r_idx == (QA+1)'(QUEUE_DEPTH));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid && s_axis_tready) n_state = ST_SCAN;
            ST_SCAN:  if (w_scan_done) n_state = ST_APPLY;
            ST_APPLY: n_state = ST_PICK;
            ST_PICK:  if (w_scan_done) n_state = ST_OUT;
            ST_OUT:   if (!r_ovalid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // memory port, apply decisions and dispatch decision
    logic   w_app;
    logic   w_do_app;
    logic   w_merge;
    logic   w_disp;
    logic   w_out_go;
    t_entry w_app_ent;
    always_comb begin
        w_raddr   = r_idx[QA-1:0];
        w_app_ent = '0;
        // append request: new job or pending re-request
        if (r_cmd == CMD_ENQUEUE) begin
            w_app            = !w_fhit && !r_hit;
            w_app_ent.reason = r_reason;
            w_app_ent.band   = r_band;
        end else begin
            w_app            = w_fhit && r_rused[w_fidx];
            w_app_ent.reason = r_rreason[w_fidx];
            w_app_ent.band   = r_rband[w_fidx];
        end
        w_app_ent.key   = r_key;
        w_app_ent.order = r_counter;
        w_do_app = (r_state == ST_APPLY) && w_app && w_qfree;
        // upgrade of a waiting entry keeps its order number
        w_merge  = (r_state == ST_APPLY) && (r_cmd == CMD_ENQUEUE) && !w_fhit && r_hit &&
                   ((r_reason > r_hit_ent.reason) || (r_band < r_hit_ent.band));
        w_we    = w_merge || w_do_app;
        w_waddr = w_merge ? r_hit_idx : w_qfidx;
        w_wdata = w_app_ent;
        if (w_merge) begin
            w_wdata        = r_hit_ent;
            w_wdata.reason = r_reason;
            w_wdata.band   = r_band;
        end
        w_disp   = r_best_v && w_ffree && (w_busy < w_limit);
        w_out_go = !r_ovalid || m_axis_tready;
    end

    function automatic logic better(t_entry a, t_entry b);
        return (a.band < b.band) || (a.band == b.band && a.order < b.order);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_limit   <= LIMIT_RESET;
            r_counter <= '0;
            r_qused   <= '0;
            r_qcount  <= '0;
            r_fused   <= '0;
            r_rused   <= '0;
            r_ovalid  <= 1'b0;
            r_rdv     <= 1'b0;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_best_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            // result register: loaded in the output step, cleared when taken
            if (r_state == ST_OUT && w_out_go) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            // scan address and read data valid, shared by both passes
            if (r_state == ST_SCAN || r_state == ST_PICK) begin
                if (w_scan_done) begin
                    r_idx <= '0;
                    r_rdv <= 1'b0;
                end else begin
                    r_idx    <= r_idx + 1'b1;
                    r_rdv    <= 1'b1;
                    r_rdaddr <= r_idx[QA-1:0];
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_cmd    <= s_axis_tuser;
                        r_key    <= s_axis_tdata[KEY_BITS-1:0];
                        r_reason <= s_axis_tdata[KEY_BITS+REASON_BITS-1:KEY_BITS];
                        r_band   <= s_axis_tdata[KEY_BITS+REASON_BITS+BAND_BITS-1:
                                                 KEY_BITS+REASON_BITS];
                        r_hit    <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    // key match against the waiting entries
                    if (r_rdv && r_qused[r_rdaddr] && !r_hit && w_rdata.key == r_key) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_rdaddr;
                        r_hit_ent <= w_rdata;
                    end
                end
                ST_APPLY: begin
                    r_dropped <= w_app && !w_qfree;
                    if (w_do_app) begin
                        r_qused[w_qfidx] <= 1'b1;
                        r_qcount  <= r_qcount + 1'b1;
                        r_counter <= r_counter + 1'b1;
                    end
                    if (r_cmd == CMD_ENQUEUE && w_fhit) begin
                        if (r_reason > r_freason[w_fidx]) begin
                            r_rused[w_fidx]   <= 1'b1;
                            r_rreason[w_fidx] <= r_reason;
                            r_rband[w_fidx]   <= r_band;
                        end
                    end else if (r_cmd == CMD_COMPLETE && w_fhit) begin
                        r_fused[w_fidx] <= 1'b0;
                        r_rused[w_fidx] <= 1'b0;
                    end
                    r_best_v <= 1'b0;
                end
                ST_PICK: begin
                    // best waiting entry whose key is not in flight
                    if (r_rdv && r_qused[r_rdaddr] && !w_rd_inflight) begin
                        if (!r_best_v || better(w_rdata, r_best_ent)) begin
                            r_best_v   <= 1'b1;
                            r_best_idx <= r_rdaddr;
                            r_best_ent <= w_rdata;
                        end
                    end
                end
                ST_OUT: begin
                    if (w_out_go) begin
                        r_dv      <= w_disp;
                        r_odrop   <= r_dropped;
                        r_okey    <= w_disp ? r_best_ent.key : '0;
                        r_oreason <= w_disp ? r_best_ent.reason : '0;
                        r_oband   <= w_disp ? r_best_ent.band : '0;
                        if (w_disp) begin
                            r_qused[r_best_idx] <= 1'b0;
                            r_fused[w_ffidx]    <= 1'b1;
                            r_fkey[w_ffidx]     <= r_best_ent.key;
                            r_freason[w_ffidx]  <= r_best_ent.reason;
                            r_rused[w_ffidx]    <= 1'b0;
                            r_ocount <= r_qcount - 1'b1;
                            r_qcount <= r_qcount - 1'b1;
                        end else begin
                            r_ocount <= r_qcount;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=>
            r_ovalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcount <= CB'(QUEUE_DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcount == CB'($countones(r_qused)))
        else $error("queue count does not match used entries");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[KEY_BITS+REASON_BITS+BAND_BITS-1:0] == '0)
        else $error("dispatch fields set without a dispatch");

endmodule

// ----- src/cpfs_ram.sv -----
module cpfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
